// File: hw/rtl/sem_pkg.sv
// Shared types and constants of the Sobel edge-magnitude block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sem_pkg;

   // size defaults and limits
   localparam int          DEF_MAX_WIDTH    = 2048;
   localparam int          CSR_W            = 12;
   localparam int          PIX_W            = 8;
   localparam int          POS_W            = 11;
   localparam int          GRAD_W           = 11;
   localparam int          ROOT_STEPS       = 8;
   localparam int          STEP_W           = $clog2(ROOT_STEPS);
   localparam logic [11:0] DEF_IMAGE_WIDTH  = 12'd640;
   localparam logic [11:0] DEF_IMAGE_HEIGHT = 12'd480;
   localparam logic [11:0] MIN_SIZE         = 12'd3;
   localparam logic [11:0] MAX_HEIGHT       = 12'd2048;

   // register indexes of the configuration port
   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic update;
      logic grad_en;
      logic square_en;
      logic sum_en;
      logic root_step;
      logic out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic emit;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/sem_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the two line buffers.
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: hw/rtl/sem_ctrl.sv
// Controller of the Sobel edge-magnitude block: sequences line-buffer clear,
// pixel intake, gradient, square, sum, root and output load. Uses sem_pkg.
module sem_ctrl import sem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_GRAD,
      S_SQUARE,
      S_SUM,
      S_ROOT,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // next state and command decode
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      step_in   = step_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.update = 1'b1;
            state_in   = sts.emit ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            cmd.grad_en = 1'b1;
            state_in    = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square_en = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            step_in    = '0;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // hold state and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: hw/rtl/sem_datapath.sv
// Datapath of the Sobel edge-magnitude block: size registers, counters, line
// buffers, 3x3 window, gradients, squares, bit-pair root and output register.
// Uses sem_pkg and sem_ram.
module sem_datapath import sem_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data,
   input  logic [PIX_W-1:0]  req_pixel,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [PIX_W-1:0]  rsp_edge_value,
   output logic [POS_W-1:0]  rsp_pixel_row,
   output logic [POS_W-1:0]  rsp_pixel_col,
   output logic              rsp_frame_last
);

   localparam int               AW     = $clog2(MAX_WIDTH);
   localparam int               WMAX   = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam logic [CSR_W-1:0] WMAX_V = CSR_W'(WMAX);

   // configuration and counters
   logic [CSR_W-1:0] width_ff, height_ff;
   logic [CSR_W-1:0] eff_w, eff_h, col_wide, row_wide;
   logic [POS_W-1:0] col_ff, row_ff;
   logic [31:0]      col_ext;
   logic [AW-1:0]    col_addr, clr_addr_ff, wr_addr;
   logic             in_store, emit, last;

   // line buffers and window
   logic [PIX_W-1:0] pixel_ff, top_rd, mid_rd, top_val, mid_val;
   logic [PIX_W-1:0] top_wdata, mid_wdata;
   logic             mem_wr;
   logic [PIX_W-1:0] win_ff [9];

   // arithmetic
   logic [9:0]              gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] prod_x, prod_y;
   logic [2*GRAD_W-2:0]     sqx_ff, sqy_ff;
   logic [2*GRAD_W-1:0]     sum;
   logic                    sat_ff;
   logic [15:0]             rem_ff, res_ff, bit_ff;
   logic [16:0]             trial;

   // result position latched at intake
   logic [POS_W-1:0] res_row_ff, res_col_ff;
   logic             res_last_ff;

   // write the size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DEF_IMAGE_WIDTH;
         height_ff <= DEF_IMAGE_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
         endcase
      end
   end

   // clamp sizes to the supported range
   always_comb begin
      priority if (width_ff < MIN_SIZE) eff_w = MIN_SIZE;
      else if (width_ff > WMAX_V)       eff_w = WMAX_V;
      else                              eff_w = width_ff;
      priority if (height_ff < MIN_SIZE) eff_h = MIN_SIZE;
      else if (height_ff > MAX_HEIGHT)   eff_h = MAX_HEIGHT;
      else                               eff_h = height_ff;
   end

   assign col_wide = {1'b0, col_ff};
   assign row_wide = {1'b0, row_ff};
   assign col_ext  = 32'(col_ff);
   assign col_addr = col_ext[AW-1:0];
   assign in_store = col_ext < 32'(MAX_WIDTH);
   assign emit     = (row_ff >= POS_W'(2)) && (col_ff >= POS_W'(2)) &&
                     (row_wide < eff_h) && (col_wide < eff_w);
   assign last     = (row_wide == eff_h - 1'b1) && (col_wide == eff_w - 1'b1);

   // advance the raster counters at intake
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.update) begin
         if (col_wide + 1'b1 >= eff_w) begin
            col_ff <= '0;
            row_ff <= (row_wide + 1'b1 >= eff_h) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // sweep the line buffers to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // line buffer write: top row takes the old middle row, middle takes the pixel
   assign mem_wr    = cmd.clear_step || (cmd.update && in_store);
   assign wr_addr   = cmd.clear_step ? clr_addr_ff : col_addr;
   assign top_wdata = cmd.clear_step ? '0 : mid_rd;
   assign mid_wdata = cmd.clear_step ? '0 : pixel_ff;

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_line (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (top_wdata),
      .rd_addr (col_addr),
      .rd_data (top_rd)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_line (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (mid_wdata),
      .rd_addr (col_addr),
      .rd_data (mid_rd)
   );

   assign top_val = in_store ? top_rd : '0;
   assign mid_val = in_store ? mid_rd : '0;

   // hold the accepted pixel
   always_ff @(posedge clock) begin
      if (cmd.accept) pixel_ff <= req_pixel;
   end

   // shift the window left and insert the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (cmd.update) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]     <= win_ff[k*3 + 1];
            win_ff[k*3 + 1] <= win_ff[k*3 + 2];
         end
         win_ff[2] <= top_val;
         win_ff[5] <= mid_val;
         win_ff[8] <= pixel_ff;
      end
   end

   // latch the result position
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         res_row_ff  <= row_ff - 1'b1;
         res_col_ff  <= col_ff - 1'b1;
         res_last_ff <= last;
      end
   end

   // gradients from the window
   assign gx_pos = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
   assign gx_neg = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
   assign gy_pos = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);
   assign gy_neg = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);

   always_ff @(posedge clock) begin
      if (cmd.grad_en) begin
         gx_ff <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
         gy_ff <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
      end
   end

   // square each gradient
   assign prod_x = gx_ff * gx_ff;
   assign prod_y = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (cmd.square_en) begin
         sqx_ff <= prod_x[2*GRAD_W-2:0];
         sqy_ff <= prod_y[2*GRAD_W-2:0];
      end
   end

   // sum, saturate, then one bit-pair root step per cycle
   assign sum   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sat_ff <= |sum[2*GRAD_W-1:16];
         rem_ff <= sum[15:0];
         res_ff <= '0;
         bit_ff <= 16'h4000;
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[15:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // output register: load a finished beat, drop it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_edge_value <= sat_ff ? 8'hFF : res_ff[PIX_W-1:0];
         rsp_pixel_row  <= res_row_ff;
         rsp_pixel_col  <= res_col_ff;
         rsp_frame_last <= res_last_ff;
      end
   end

   // status to the controller
   always_comb begin
      sts.clear_last = (clr_addr_ff == AW'(MAX_WIDTH - 1));
      sts.emit       = emit;
      sts.out_free   = !rsp_valid || rsp_ready;
   end

endmodule

// File: hw/rtl/sobel_edge_magnitude.sv
// Top level of the 3x3 Sobel edge-magnitude filter on a greyscale raster stream.
// Uses sem_pkg, sem_ctrl and sem_datapath.
//
//   channel   ports                                   direction  role
//   req       req_valid/ready, req_pixel              in         one pixel per beat
//   rsp       rsp_valid/ready, rsp_edge_value, ...    out        one interior result
//   csr       csr_wr_en, csr_index, csr_wr_data       in         size register write
//
// A pixel that gives no result goes through intake, line-buffer read and
// window shift; one that gives a result goes on through gradient, square,
// sum and the bit-pair square root, one result bit per cycle.
// After reset the line buffers are cleared while req_ready is low.
// A waiting result sits in the output register while the next pixel is taken; a
// new result waits in the controller until that register is free.
module sobel_edge_magnitude import sem_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PIX_W-1:0]  req_pixel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_edge_value,
   output logic [POS_W-1:0]  rsp_pixel_row,
   output logic [POS_W-1:0]  rsp_pixel_col,
   output logic              rsp_frame_last,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequence each beat
   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and arithmetic
   sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_pixel      (req_pixel),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_edge_value (rsp_edge_value),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// File: hw/rtl/sem_checker.sv
// Port-level checks of the Sobel edge-magnitude block, bound to its top level.
// Depends on sobel_edge_magnitude and sem_pkg widths.
module sem_checker import sem_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_edge_value,
   input logic [POS_W-1:0] rsp_pixel_row,
   input logic [POS_W-1:0] rsp_pixel_col,
   input logic             rsp_frame_last
);

   // reset leaves no result pending and holds off intake for the clear
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or intake right after reset");

   // one pixel at a time: intake closes after each beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second pixel taken in back-to-back cycles");

   // results only for interior pixels: row and column neither zero nor all ones
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_row != '0 && rsp_pixel_col != '0 &&
                    rsp_pixel_row != '1 && rsp_pixel_col != '1)
      else $error("result for a border position");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_value) &&
         $stable(rsp_pixel_row) && $stable(rsp_pixel_col) && $stable(rsp_frame_last))
      else $error("stalled result changed");

endmodule

bind sobel_edge_magnitude sem_checker u_checker (.*);

// File: tb/sv/sem_tb_pkg.sv
`timescale 1ns / 1ps
// Edge-magnitude scoreboard: predicts the interior results from accepted pixels
// and checks returned result beats in order. Depends on sem_pkg.
package sem_tb_pkg;
   import sem_pkg::*;

   localparam int LINE_W      = DEF_MAX_WIDTH;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic [PIX_W-1:0] mag;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } edge_beat_type;

   class edge_magnitude_checker;
      logic [PIX_W-1:0] line_mem [2*LINE_W];
      logic [PIX_W-1:0] win [9];
      int unsigned      col_cnt;
      int unsigned      row_cnt;
      logic [CSR_W-1:0] width_reg;
      logic [CSR_W-1:0] height_reg;
      edge_beat_type    pending_edges [$];
      int               errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[i]) win[i] = '0;
         col_cnt    = 0;
         row_cnt    = 0;
         width_reg  = DEF_IMAGE_WIDTH;
         height_reg = DEF_IMAGE_HEIGHT;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      // clamp the row length to at least MIN_SIZE and to what the line store can hold
      function int unsigned eff_width();
         int unsigned hi;
         hi = (LINE_W < 2048) ? LINE_W : 2048;
         if (width_reg < MIN_SIZE) return MIN_SIZE;
         if (width_reg > hi) return hi;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg < MIN_SIZE) return MIN_SIZE;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return height_reg;
      endfunction

      function bit at_frame_start();
         return col_cnt == 0 && row_cnt == 0;
      endfunction

      function int waiting();
         return pending_edges.size();
      endfunction

      // build the root one bit at a time from the top
      function logic [PIX_W-1:0] root_floor(int unsigned sq);
         int unsigned m;
         int unsigned t;
         m = 0;
         for (int b = 7; b >= 0; b--) begin
            t = m | (32'd1 << b);
            if (t * t <= sq) m = t;
         end
         return m[PIX_W-1:0];
      endfunction

      // advance the window by one pixel and queue the result it completes
      function void take_pixel(logic [PIX_W-1:0] p);
         int unsigned      w, h, c, r, sq;
         int               gx, gy;
         logic [PIX_W-1:0] top, mid;
         edge_beat_type    e;
         w   = eff_width();
         h   = eff_height();
         c   = col_cnt;
         r   = row_cnt;
         top = '0;
         mid = '0;
         if (c < LINE_W) begin
            top = line_mem[LINE_W + c];
            mid = line_mem[c];
            line_mem[LINE_W + c] = mid;
            line_mem[c] = p;
         end
         for (int k = 0; k < 3; k++) begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = p;
         if (r >= 2 && c >= 2 && r < h && c < w) begin
            gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
            gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            sq     = gx * gx + gy * gy;
            e.mag  = (sq >= 65536) ? 8'hFF : root_floor(sq);
            e.row  = POS_W'(r - 1);
            e.col  = POS_W'(c - 1);
            e.last = (r == h - 1 && c == w - 1);
            pending_edges.push_back(e);
         end
         // wrap the column, then the row, at the current size
         if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : ((r + 1) & 'h7FF);
         end else begin
            col_cnt = (c + 1) & 'h7FF;
         end
      endfunction

      task report(string msg);
         if (errors < MAX_REPORTS) $display("%0d ns mismatch: %s", $time, msg);
         errors++;
      endtask

      // compare one result beat with the oldest prediction
      task check_beat(logic [PIX_W-1:0] mag, logic [POS_W-1:0] row,
                      logic [POS_W-1:0] col, logic last);
         edge_beat_type e;
         if (pending_edges.size() == 0) begin
            report($sformatf("result with none pending: row %0d col %0d value %0d",
                             row, col, mag));
            return;
         end
         e = pending_edges.pop_front();
         if (mag !== e.mag)
            report($sformatf("edge_value at row %0d col %0d: got %0d, want %0d",
                             e.row, e.col, mag, e.mag));
         if (row !== e.row)
            report($sformatf("pixel_row: got %0d, want %0d", row, e.row));
         if (col !== e.col)
            report($sformatf("pixel_col at row %0d: got %0d, want %0d", e.row, col, e.col));
         if (last !== e.last)
            report($sformatf("frame_last at row %0d col %0d: got %0b, want %0b",
                             e.row, e.col, last, e.last));
      endtask
   endclass

endpackage

// File: tb/sv/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// Top of the sobel_edge_magnitude testbench: pixel and size-register drivers,
// result sink with random stalls, watchdog. Depends on sem_pkg and sem_tb_pkg.
module tb_sobel_edge_magnitude;
   import sem_pkg::*;
   import sem_tb_pkg::*;

   localparam int SETTLE_CYCLES = 32;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_PIXELS = 1800;

   // three 3x3 frames: full-scale rising column step, full-scale falling row
   // step, and a small corner step below saturation
   localparam logic [PIX_W-1:0] EDGE_FRAMES [27] = '{
      8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd128, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd60
   };

   typedef enum int { PIX_ANY, PIX_BINARY, PIX_DIM, PIX_FLAT } pix_style_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic [PIX_W-1:0] req_pixel   = '0;
   logic             rsp_ready   = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic             csr_index   = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0] csr_wr_data = '0;
   logic             req_ready;
   logic             rsp_valid;
   logic [PIX_W-1:0] rsp_edge_value;
   logic [POS_W-1:0] rsp_pixel_row;
   logic [POS_W-1:0] rsp_pixel_col;
   logic             rsp_frame_last;

   edge_magnitude_checker edges;
   bit               tx_bursty   = 1'b0;
   bit               rx_bursty   = 1'b0;
   int               rsp_hold    = 0;
   int               pixels_sent = 0;
   pix_style_type    style       = PIX_ANY;
   logic [PIX_W-1:0] flat_level  = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sobel_edge_magnitude dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CSR_W-1:0] pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return CSR_W'($urandom_range(0, 2));
      if (r < 12) return CSR_W'($urandom_range(11, 40));
      return CSR_W'($urandom_range(3, 10));
   endfunction

   function automatic logic [CSR_W-1:0] pick_height();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return CSR_W'($urandom_range(0, 2));
      if (r < 11) return CSR_W'($urandom_range(9, 20));
      return CSR_W'($urandom_range(3, 8));
   endfunction

   function automatic logic [PIX_W-1:0] gen_pixel();
      case (style)
         PIX_ANY:    return PIX_W'($urandom_range(0, 255));
         PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         PIX_DIM:    return PIX_W'($urandom_range(0, 15));
         default:    return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 255))
                                                       : flat_level;
      endcase
   endfunction

   // result side: stall at random when rx_bursty is set, accept and check each beat
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rx_bursty) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         edges.check_beat(rsp_edge_value, rsp_pixel_row, rsp_pixel_col, rsp_frame_last);
   end

   // offer one pixel, hold it until the beat is taken, then predict
   task automatic send_pixel(input logic [PIX_W-1:0] p);
      int gap;
      gap = tx_bursty ? pick_gap() : 0;
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (!req_ready);
      edges.take_pixel(p);
      pixels_sent++;
   endtask

   // drop valid and hold until every predicted result has come back
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (edges.waiting() != 0) @(posedge clock);
   endtask

   // write both size registers once the block has gone idle
   task automatic set_size(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_IMAGE_WIDTH;
      csr_wr_data <= w;
      @(negedge clock);
      csr_index   <= CSR_IMAGE_HEIGHT;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      edges.write_reg(CSR_IMAGE_WIDTH, w);
      edges.write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic send_run(input int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(gen_pixel());
         if (tx_bursty && $urandom_range(0, 299) == 0) drain();
      end
   endtask

   // finish a frame left open by an earlier run or a size change
   task automatic align_frame();
      while (!edges.at_frame_start()) send_pixel(gen_pixel());
   endtask

   // watchdog: end the run when nothing moves on either channel for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_sobel_edge_magnitude failed");
      $finish;
   end

   initial begin
      int random_start;
      int frame_px;
      edges = new();
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: smallest frame, saturated and unsaturated gradients
      set_size(12'd3, 12'd3);
      for (int i = 0; i < 27; i++) send_pixel(EDGE_FRAMES[i]);

      // out-of-range width clamps to the line store, height to three; left mid-row
      tx_bursty = 1'b1;
      rx_bursty = 1'b1;
      style     = PIX_ANY;
      set_size(12'd4095, 12'd2);
      send_run($urandom_range(30, 90));

      // oversized height abandoned mid-frame, then a wide row started past it
      set_size(12'd3, 12'd4095);
      send_run($urandom_range(30, 90));
      set_size(12'd2048, 12'd3);
      send_run($urandom_range(20, 60));

      // random sizes, content and pacing; some runs stop mid-frame
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         tx_bursty  = $urandom_range(0, 3) != 0;
         rx_bursty  = $urandom_range(0, 3) != 0;
         style      = pix_style_type'($urandom_range(0, 3));
         flat_level = PIX_W'($urandom_range(0, 255));
         set_size(pick_width(), pick_height());
         frame_px = edges.eff_width() * edges.eff_height();
         if ($urandom_range(0, 6) == 0) begin
            send_run($urandom_range(1, frame_px));
         end else begin
            align_frame();
            send_run($urandom_range(1, 3) * frame_px);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (edges.errors == 0 && edges.waiting() == 0) begin
         $display("tb_sobel_edge_magnitude passed");
      end else begin
         $display("tb_sobel_edge_magnitude failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sem_ctrl.sv
hw/rtl/sem_datapath.sv
hw/rtl/sobel_edge_magnitude.sv
hw/rtl/sem_checker.sv
tb/sv/sem_tb_pkg.sv
tb/sv/tb_sobel_edge_magnitude.sv
